[sv/tkd_pkg.sv]
// Package for the terminal key decoder: item structs, key and class codes,
// decoder mode encoding and byte constants. No dependencies.
package tkd_pkg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  key_code;
        logic [31:0] char_bytes;
        logic [2:0]  char_len;
    } t_out_item;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_EOF  = 2'd2;

    localparam logic [4:0] K_EOF   = 5'd0;
    localparam logic [4:0] K_CTRLA = 5'd1;
    localparam logic [4:0] K_CTRLC = 5'd2;
    localparam logic [4:0] K_CTRLD = 5'd3;
    localparam logic [4:0] K_CTRLE = 5'd4;
    localparam logic [4:0] K_CTRLN = 5'd5;
    localparam logic [4:0] K_CTRLP = 5'd6;
    localparam logic [4:0] K_CTRLU = 5'd7;
    localparam logic [4:0] K_ENTER = 5'd8;
    localparam logic [4:0] K_BKSP  = 5'd9;
    localparam logic [4:0] K_ESC   = 5'd10;
    localparam logic [4:0] K_UP    = 5'd11;
    localparam logic [4:0] K_DOWN  = 5'd12;
    localparam logic [4:0] K_RIGHT = 5'd13;
    localparam logic [4:0] K_LEFT  = 5'd14;
    localparam logic [4:0] K_HOME  = 5'd15;
    localparam logic [4:0] K_END   = 5'd16;
    localparam logic [4:0] K_CHAR  = 5'd17;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_ESC  = 4'b0010,
        MODE_SEQ  = 4'b0100,
        MODE_UTF8 = 4'b1000
    } t_mode;

    typedef enum logic [1:0] {
        CLS_EMPTY = 2'd0,
        CLS_HOME  = 2'd1,
        CLS_END   = 2'd2,
        CLS_OTHER = 2'd3
    } t_cls;

    localparam logic [7:0] B_ESC     = 8'h1b;
    localparam logic [7:0] B_DEL     = 8'h7f;
    localparam logic [7:0] B_BS      = 8'h08;
    localparam logic [7:0] B_CR      = 8'h0d;
    localparam logic [7:0] B_LF      = 8'h0a;
    localparam logic [7:0] B_CSI     = 8'h5b;
    localparam logic [7:0] B_SS3     = 8'h4f;
    localparam logic [7:0] B_FIN_LO  = 8'h40;
    localparam logic [7:0] B_FIN_HI  = 8'h7e;
    localparam logic [7:0] B_SPACE   = 8'h20;
    localparam logic [9:0] WAIT_MAX  = 10'h3ff;

    localparam logic [9:0] TIMEOUT_RESET = 10'd50;

endpackage

[sv/tkd_core.sv]
// Decoder state and per-item next-state/result logic for the key decoder.
// Depends on tkd_pkg.
module tkd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  tkd_pkg::t_in_item i_item,
    input  logic [9:0]        i_timeout,
    output logic              o_fire,
    output tkd_pkg::t_out_item o_result
);
    import tkd_pkg::*;

    t_mode       r_mode, n_mode;
    logic [9:0]  r_wait, n_wait;
    t_cls        r_cls, n_cls;
    logic [31:0] r_buf, n_buf;
    logic [2:0]  r_held, n_held;
    logic [2:0]  r_need, n_need;

    logic [7:0]  c;
    logic [2:0]  extra;
    logic [9:0]  wait_inc;

    always_comb begin
        c        = i_item.data_byte;
        n_mode   = r_mode;
        n_wait   = r_wait;
        n_cls    = r_cls;
        n_buf    = r_buf;
        n_held   = r_held;
        n_need   = r_need;
        o_fire   = 1'b0;
        o_result = '0;
        extra    = 3'd0;
        wait_inc = (r_wait == WAIT_MAX) ? r_wait : r_wait + 10'd1;

        if (c[7:5] == 3'b110) begin
            extra = 3'd1;
        end else if (c[7:4] == 4'b1110) begin
            extra = 3'd2;
        end else if (c[7:3] == 5'b11110) begin
            extra = 3'd3;
        end

        case (i_item.req_type)
            REQ_BYTE: begin
                unique case (r_mode)
                    MODE_IDLE: begin
                        o_fire = 1'b1;
                        unique case (c)
                            8'h01: o_result.key_code = K_CTRLA;
                            8'h03: o_result.key_code = K_CTRLC;
                            8'h04: o_result.key_code = K_CTRLD;
                            8'h05: o_result.key_code = K_CTRLE;
                            8'h0e: o_result.key_code = K_CTRLN;
                            8'h10: o_result.key_code = K_CTRLP;
                            8'h15: o_result.key_code = K_CTRLU;
                            B_CR, B_LF: o_result.key_code = K_ENTER;
                            B_DEL, B_BS: o_result.key_code = K_BKSP;
                            B_ESC: begin
                                o_fire = 1'b0;
                                n_mode = MODE_ESC;
                                n_wait = '0;
                            end
                            default: begin
                                if (c < B_SPACE) begin
                                    o_fire = 1'b0;
                                end else if (extra == 3'd0) begin
                                    o_result.key_code   = K_CHAR;
                                    o_result.char_bytes = {24'd0, c};
                                    o_result.char_len   = 3'd1;
                                end else begin
                                    o_fire = 1'b0;
                                    n_buf  = {24'd0, c};
                                    n_held = 3'd1;
                                    n_need = extra + 3'd1;
                                    n_mode = MODE_UTF8;
                                end
                            end
                        endcase
                    end
                    MODE_ESC: begin
                        if (c == B_CSI || c == B_SS3) begin
                            n_mode = MODE_SEQ;
                            n_cls  = CLS_EMPTY;
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_SEQ: begin
                        if (c < B_FIN_LO || c > B_FIN_HI) begin
                            if (r_cls == CLS_EMPTY) begin
                                if (c == 8'h31 || c == 8'h37) begin
                                    n_cls = CLS_HOME;
                                end else if (c == 8'h34 || c == 8'h38) begin
                                    n_cls = CLS_END;
                                end else begin
                                    n_cls = CLS_OTHER;
                                end
                            end else begin
                                n_cls = CLS_OTHER;
                            end
                        end else begin
                            n_mode = MODE_IDLE;
                            o_fire = 1'b1;
                            unique case (c)
                                8'h41: o_result.key_code = K_UP;
                                8'h42: o_result.key_code = K_DOWN;
                                8'h43: o_result.key_code = K_RIGHT;
                                8'h44: o_result.key_code = K_LEFT;
                                8'h48: o_result.key_code = K_HOME;
                                8'h46: o_result.key_code = K_END;
                                B_FIN_HI: begin
                                    if (r_cls == CLS_HOME) begin
                                        o_result.key_code = K_HOME;
                                    end else if (r_cls == CLS_END) begin
                                        o_result.key_code = K_END;
                                    end else begin
                                        o_fire = 1'b0;
                                    end
                                end
                                default: o_fire = 1'b0;
                            endcase
                        end
                    end
                    MODE_UTF8: begin
                        n_buf  = r_buf | ({24'd0, c} << {r_held[1:0], 3'b000});
                        n_held = r_held + 3'd1;
                        if (n_held >= r_need) begin
                            n_mode              = MODE_IDLE;
                            o_fire              = 1'b1;
                            o_result.key_code   = K_CHAR;
                            o_result.char_bytes = n_buf;
                            o_result.char_len   = n_held;
                        end
                    end
                    default: n_mode = MODE_IDLE;
                endcase
            end
            REQ_TICK: begin
                if (r_mode == MODE_ESC) begin
                    n_wait = wait_inc;
                    if (wait_inc >= i_timeout) begin
                        n_mode            = MODE_IDLE;
                        o_fire            = 1'b1;
                        o_result.key_code = K_ESC;
                    end
                end
            end
            REQ_EOF: begin
                n_mode = MODE_IDLE;
                o_fire = 1'b1;
                if (r_mode == MODE_IDLE) begin
                    o_result.key_code = K_EOF;
                end else if (r_mode == MODE_UTF8) begin
                    o_result.key_code   = K_CHAR;
                    o_result.char_bytes = r_buf;
                    o_result.char_len   = r_held;
                end else begin
                    o_result.key_code = K_ESC;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_wait <= '0;
            r_cls  <= CLS_EMPTY;
            r_buf  <= '0;
            r_held <= '0;
            r_need <= '0;
        end else if (i_go) begin
            r_mode <= n_mode;
            r_wait <= n_wait;
            r_cls  <= n_cls;
            r_buf  <= n_buf;
            r_held <= n_held;
            r_need <= n_need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && i_go && r_mode == MODE_UTF8 && i_item.req_type == REQ_BYTE) begin
            assert (r_held != 3'd0 && r_held < r_need)
                else $error("utf8 gather count out of range");
        end
    end

endmodule

[sv/terminal_key_decoder.sv]
// Terminal key decoder top level: input register, decoder core, result
// register and the APB-style timeout register. Depends on tkd_pkg, tkd_core.
// Items pass the input register; a key (if any) is then registered in the result register.
// Throughput: one item per cycle; input stalls only while a held item meets a stalled result.
// The decoder state updates in the cycle an item moves from input to result register.
// Reset (synchronous, active low): decoder idle, both stages empty, timeout 50 ticks.
module terminal_key_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tkd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tkd_pkg::t_out_item  o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tkd_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic [9:0] r_timeout;

    logic       proc_go;
    logic       core_go;
    logic       core_fire;
    t_out_item  core_result;

    assign proc_go    = !r_out_valid || !i_out_stall;
    assign core_go    = r_in_valid && proc_go;
    assign o_in_stall = r_in_valid && !proc_go;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == 1'b0) ? {22'd0, r_timeout} : 32'd0;

    tkd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (core_go),
        .i_item    (r_in_item),
        .i_timeout (r_timeout),
        .o_fire    (core_fire),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc_go) begin
                r_out_valid <= core_go && core_fire;
            end
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
                r_timeout <= pwdata[9:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (core_go && core_fire) begin
            r_out_item <= core_result;
        end
    end

    a_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.key_code == K_CHAR |->
            o_out_item.char_len != 3'd0 && o_out_item.char_len <= 3'd4)
        else $error("char item with bad length");

    a_nonchar_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.key_code != K_CHAR |->
            o_out_item.char_len == 3'd0 && o_out_item.char_bytes == 32'd0)
        else $error("non-char item carries char bytes");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.key_code <= K_CHAR)
        else $error("key code out of range");

endmodule
